FILE: rtl/core/sdh_pkg.sv
package sdh_pkg;

    localparam int FINGERS_DEF = 5;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SEEK_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_CURRENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_DUTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd5;

    localparam logic [11:0] SEEK_DUTY_RST     = 12'd1024;
    localparam logic [15:0] STALL_CURRENT_RST = 16'd800;
    localparam logic [15:0] TIMEOUT_RST       = 16'd3000;
    localparam logic [11:0] BACKOFF_DUTY_RST  = 12'd512;
    localparam logic [15:0] BACKOFF_TIME_RST  = 16'd200;
    localparam logic [11:0] MAX_DUTY_RST      = 12'd4095;

    localparam logic [2:0] SC_IDLE     = 3'd0;
    localparam logic [2:0] SC_REQUEST  = 3'd1;
    localparam logic [2:0] SC_MOVING   = 3'd2;
    localparam logic [2:0] SC_AT_LIMIT = 3'd3;
    localparam logic [2:0] SC_COMPLETE = 3'd4;
    localparam logic [2:0] SC_FAULT    = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_REQUEST  = 6'b000010,
        PH_MOVING   = 6'b000100,
        PH_AT_LIMIT = 6'b001000,
        PH_COMPLETE = 6'b010000,
        PH_FAULT    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [11:0] seek_duty;
        logic [15:0] stall_ma;
        logic [15:0] timeout_ms;
        logic [11:0] backoff_duty;
        logic [15:0] backoff_ms;
        logic [11:0] max_duty;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  delta_ms;
        logic        fault;
        logic [15:0] motor_ma;
        logic [11:0] reported_duty;
        logic [3:0]  query_channel;
    } item_t;

    typedef struct packed {
        logic [2:0]  state_code;
        logic [3:0]  finger_index;
        logic        duty_write;
        logic [11:0] duty_value;
        logic        stop_all;
        logic        save_pulse;
        logic        ready_res;
        logic [11:0] limit_value;
    } res_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:     code = SC_IDLE;
            PH_REQUEST:  code = SC_REQUEST;
            PH_MOVING:   code = SC_MOVING;
            PH_AT_LIMIT: code = SC_AT_LIMIT;
            PH_COMPLETE: code = SC_COMPLETE;
            PH_FAULT:    code = SC_FAULT;
            default:     code = SC_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/core/sdh_cfg_regs.sv
module sdh_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [sdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output sdh_pkg::cfg_t                 cfg
);
    import sdh_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seek_duty    <= SEEK_DUTY_RST;
            cfg_reg.stall_ma     <= STALL_CURRENT_RST;
            cfg_reg.timeout_ms   <= TIMEOUT_RST;
            cfg_reg.backoff_duty <= BACKOFF_DUTY_RST;
            cfg_reg.backoff_ms   <= BACKOFF_TIME_RST;
            cfg_reg.max_duty     <= MAX_DUTY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEEK_DUTY:     cfg_reg.seek_duty    <= cfg_data[11:0];
                REG_STALL_CURRENT: cfg_reg.stall_ma     <= cfg_data;
                REG_TIMEOUT:       cfg_reg.timeout_ms   <= cfg_data;
                REG_BACKOFF_DUTY:  cfg_reg.backoff_duty <= cfg_data[11:0];
                REG_BACKOFF_TIME:  cfg_reg.backoff_ms   <= cfg_data;
                REG_MAX_DUTY:      cfg_reg.max_duty     <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/sdh_step.sv
module sdh_step #(
    parameter int FINGERS = sdh_pkg::FINGERS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  sdh_pkg::item_t item,
    input  sdh_pkg::cfg_t  cfg,
    output sdh_pkg::res_t  res
);
    import sdh_pkg::*;

    localparam int IDX_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;
    localparam logic [4:0] FINGER_CNT = 5'(FINGERS);

    phase_t      phase_reg, phase_next;
    logic [3:0]  finger_reg, finger_next;
    logic [15:0] time_reg, time_next;
    logic [11:0] limit_store_reg [FINGERS];

    logic [16:0]      sum;
    logic [15:0]      elapsed;
    logic             wr_en;
    logic [11:0]      wr_val;
    logic             q_ok;
    logic [IDX_W-1:0] q_idx;
    logic [IDX_W-1:0] f_idx;
    logic             keep_finger;

    assign f_idx = finger_reg[IDX_W-1:0];
    assign q_idx = item.query_channel[IDX_W-1:0];
    assign q_ok  = {1'b0, item.query_channel} < FINGER_CNT;

    always_comb
    begin
        sum         = {1'b0, time_reg} + {9'b0, item.delta_ms};
        elapsed     = sum[16] ? 16'hFFFF : sum[15:0];
        phase_next  = phase_reg;
        finger_next = finger_reg;
        time_next   = elapsed;
        wr_en       = 1'b0;
        wr_val      = item.reported_duty;
        keep_finger = 1'b0;
        res         = '0;

        if (item.mode)
        begin
            finger_next = 4'd0;
            phase_next  = PH_REQUEST;
            time_next   = 16'd0;
        end
        else if (phase_reg inside {PH_REQUEST, PH_MOVING, PH_AT_LIMIT, PH_FAULT})
        begin
            if (item.fault)
            begin
                res.stop_all = 1'b1;
                phase_next   = PH_FAULT;
                time_next    = 16'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_REQUEST:
                    begin
                        res.duty_write = 1'b1;
                        res.duty_value = cfg.seek_duty;
                        phase_next     = PH_MOVING;
                        time_next      = 16'd0;
                    end
                    PH_MOVING:
                    begin
                        if (item.motor_ma >= cfg.stall_ma)
                        begin
                            wr_en = 1'b1;
                        end
                        else if (elapsed > cfg.timeout_ms)
                        begin
                            wr_en  = 1'b1;
                            wr_val = cfg.max_duty;
                        end
                        if (wr_en)
                        begin
                            res.duty_write = 1'b1;
                            phase_next     = PH_AT_LIMIT;
                            time_next      = 16'd0;
                        end
                    end
                    PH_AT_LIMIT:
                    begin
                        res.duty_write = 1'b1;
                        res.duty_value = cfg.backoff_duty;
                        if (elapsed >= cfg.backoff_ms)
                        begin
                            res.duty_value = 12'd0;
                            time_next      = 16'd0;
                            if ({1'b0, finger_reg} + 5'd1 >= FINGER_CNT)
                            begin
                                res.save_pulse = 1'b1;
                                phase_next     = PH_COMPLETE;
                            end
                            else
                            begin
                                keep_finger = 1'b1;
                                finger_next = finger_reg + 4'd1;
                                phase_next  = PH_REQUEST;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        res.state_code   = phase_code(phase_next);
        res.finger_index = keep_finger ? finger_reg : finger_next;
        res.ready_res    = (phase_next == PH_COMPLETE);
        if (q_ok)
        begin
            res.limit_value = (wr_en && q_idx == f_idx) ? wr_val : limit_store_reg[q_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            finger_reg <= 4'd0;
            time_reg   <= 16'd0;
            for (int i = 0; i < FINGERS; i++)
            begin
                limit_store_reg[i] <= MAX_DUTY_RST;
            end
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            finger_reg <= finger_next;
            time_reg   <= time_next;
            if (wr_en)
            begin
                limit_store_reg[f_idx] <= wr_val;
            end
        end
    end

endmodule

FILE: rtl/core/stall_detect_homing_sequencer_unit.sv
// Path: an accepted item waits in the input register, and its result is registered into res_reg.
// Throughput: one item per cycle while the result side keeps up; a stalled result
// holds the next item in the input register and then stalls the input.
// The step itself is one compare-and-select pass on the phase registers.
// Reset (rst_n, asynchronous, active low) restores register defaults, the idle
// phase, finger zero, zero phase time and every stored limit at 4095.
module stall_detect_homing_sequencer_unit #(
    parameter int FINGERS = sdh_pkg::FINGERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [7:0]                    delta_ms,
    input  logic                          fault,
    input  logic [15:0]                   motor_ma,
    input  logic [11:0]                   reported_duty,
    input  logic [3:0]                    query_channel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    state_code,
    output logic [3:0]                    finger_index,
    output logic                          duty_write,
    output logic [11:0]                   duty_value,
    output logic                          stop_all,
    output logic                          save_pulse,
    output logic                          ready_res,
    output logic [11:0]                   limit_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import sdh_pkg::*;

    logic  in_valid_reg;
    item_t item_reg;
    logic  out_valid_reg;
    res_t  res_reg;
    res_t  res_next;
    cfg_t  cfg;
    logic  advance;
    logic  in_take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    sdh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdh_step #(
        .FINGERS (FINGERS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode          <= mode;
            item_reg.delta_ms      <= delta_ms;
            item_reg.fault         <= fault;
            item_reg.motor_ma      <= motor_ma;
            item_reg.reported_duty <= reported_duty;
            item_reg.query_channel <= query_channel;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign state_code   = res_reg.state_code;
    assign finger_index = res_reg.finger_index;
    assign duty_write   = res_reg.duty_write;
    assign duty_value   = res_reg.duty_value;
    assign stop_all     = res_reg.stop_all;
    assign save_pulse   = res_reg.save_pulse;
    assign ready_res    = res_reg.ready_res;
    assign limit_value  = res_reg.limit_value;

endmodule
